### src/lkws_pkg.sv
// ----------------------------------------------------------------------------
// lkws_pkg
// Types and constants shared by the latency Kalman/window statistics block.
// ----------------------------------------------------------------------------
package lkws_pkg;

	localparam int LAT_W   = 30;
	localparam int SLOPE_W = 31;
	localparam int VAR_W   = 41;
	localparam int FILL_W  = 7;
	localparam int CFG_W   = 24;
	localparam int ERR_W   = 32;
	localparam int GAIN_W  = 17;
	localparam int DIV_W   = 64;

	localparam logic [LAT_W-1:0] LAT_MIN   = LAT_W'(65536);
	localparam logic [LAT_W-1:0] LAT_MAX   = LAT_W'(655360000);
	localparam logic [LAT_W-1:0] SLOPE_MAX = LAT_W'(655360000);

	localparam logic [CFG_W-1:0] PN_RESET  = CFG_W'(655);
	localparam logic [CFG_W-1:0] MN_RESET  = CFG_W'(327680);
	localparam logic [ERR_W-1:0] ERR_RESET = ERR_W'(65536);

	localparam int MIN_SLOPE_N = 10;
	localparam int MIN_VAR_N   = 5;

	// register indexes
	localparam logic REG_PROCESS_NOISE     = 1'b0;
	localparam logic REG_MEASUREMENT_NOISE = 1'b1;

	typedef struct packed {
		logic [CFG_W-1:0] process_noise;
		logic [CFG_W-1:0] measurement_noise;
	} kal_cfg_t;

	typedef struct packed {
		logic             valid;
		logic [LAT_W-1:0] sample;
	} q_word_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

### src/latency_kalman_window_stats.sv
// ----------------------------------------------------------------------------
// latency_kalman_window_stats
// Per word: five divisions on the shared bit-serial divider and two window
// sweeps with n >= 10 words held, four divisions and two sweeps with 5..9, two
// divisions and one sweep below 5 (n counts the new word); zero total noise
// skips the two filter divisions. One word is handled at a time, the next
// only after the last result goes to the output; two words queue in front.
// Reset: estimate 0, error 1.0, window empty, registers to defaults; no sweep.
// ----------------------------------------------------------------------------
module latency_kalman_window_stats #(
	parameter int WINDOW = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [lkws_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [lkws_pkg::LAT_W-1:0]          latency_sample,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [lkws_pkg::LAT_W-1:0]          filtered_latency,
	output logic signed [lkws_pkg::SLOPE_W-1:0] trend_slope,
	output logic [lkws_pkg::VAR_W-1:0]          latency_variance,
	output logic [lkws_pkg::FILL_W-1:0]         window_fill
);
	import lkws_pkg::*;

	kal_cfg_t cfg_q;
	q_word_t  q_head;
	logic     q_pop;
	div_req_t div_req;
	div_rsp_t div_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.process_noise     <= PN_RESET;
			cfg_q.measurement_noise <= MN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PROCESS_NOISE:     cfg_q.process_noise     <= cfg_data;
				REG_MEASUREMENT_NOISE: cfg_q.measurement_noise <= cfg_data;
			endcase
		end
	end

	lkws_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.latency_sample (latency_sample),
		.q_head         (q_head),
		.q_pop          (q_pop)
	);

	lkws_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	lkws_back #(
		.WINDOW (WINDOW)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.q_head           (q_head),
		.q_pop            (q_pop),
		.div_req          (div_req),
		.div_rsp          (div_rsp),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.filtered_latency (filtered_latency),
		.trend_slope      (trend_slope),
		.latency_variance (latency_variance),
		.window_fill      (window_fill)
	);

endmodule

### src/lkws_front.sv
// ----------------------------------------------------------------------------
// lkws_front
// Takes sample words, clamps them to 1..10000 ms and queues them (two deep).
// ----------------------------------------------------------------------------
module lkws_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [lkws_pkg::LAT_W-1:0]  latency_sample,
	output lkws_pkg::q_word_t           q_head,
	input  logic                        q_pop
);
	import lkws_pkg::*;

	logic [LAT_W-1:0] q_data_q [2];
	logic             wr_q, rd_q;
	logic [1:0]       n_q;
	logic             push;
	logic [LAT_W-1:0] clamped;

	assign in_stall = (n_q == 2'd2);
	assign push     = in_valid && !in_stall;

	always_comb begin
		priority if (latency_sample < LAT_MIN)
			clamped = LAT_MIN;
		else if (latency_sample > LAT_MAX)
			clamped = LAT_MAX;
		else
			clamped = latency_sample;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			n_q  <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (q_pop)
				rd_q <= ~rd_q;
			n_q <= n_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			q_data_q[wr_q] <= clamped;
	end

	assign q_head.valid  = (n_q != 2'd0);
	assign q_head.sample = q_data_q[rd_q];

endmodule

### src/lkws_div.sv
// ----------------------------------------------------------------------------
// lkws_div
// Shared restoring divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module lkws_div (
	input  logic               clk,
	input  logic               arst_n,
	input  lkws_pkg::div_req_t req,
	output lkws_pkg::div_rsp_t rsp
);
	import lkws_pkg::*;

	localparam int CNT_W = $clog2(DIV_W);

	logic [DIV_W-1:0] rem_q, quo_q, dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic [DIV_W:0]   trial;
	logic             ge;
	logic [DIV_W:0]   diff;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == CNT_W'(DIV_W - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_W - 1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

### src/lkws_back.sv
// ----------------------------------------------------------------------------
// lkws_back
// Kalman update, window store and the slope/variance sweeps for one word.
// ----------------------------------------------------------------------------
module lkws_back #(
	parameter int WINDOW = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lkws_pkg::kal_cfg_t            cfg,
	input  lkws_pkg::q_word_t             q_head,
	output logic                          q_pop,
	output lkws_pkg::div_req_t            div_req,
	input  lkws_pkg::div_rsp_t            div_rsp,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [lkws_pkg::LAT_W-1:0]    filtered_latency,
	output logic signed [lkws_pkg::SLOPE_W-1:0] trend_slope,
	output logic [lkws_pkg::VAR_W-1:0]    latency_variance,
	output logic [lkws_pkg::FILL_W-1:0]   window_fill
);
	import lkws_pkg::*;

	localparam int AW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CW   = $clog2(WINDOW + 1);
	localparam int SYW  = LAT_W + AW;
	localparam int SXYW = LAT_W + 2 * AW;
	localparam int SXW  = 2 * AW;
	localparam int SX2W = 3 * AW;
	localparam int TW   = 45;
	localparam int VSW  = TW + AW;

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_PREP    = 5'd1;
	localparam logic [4:0] S_DEN     = 5'd2;
	localparam logic [4:0] S_G_GO    = 5'd3;
	localparam logic [4:0] S_G_WAIT  = 5'd4;
	localparam logic [4:0] S_E_GO    = 5'd5;
	localparam logic [4:0] S_E_WAIT  = 5'd6;
	localparam logic [4:0] S_MV      = 5'd7;
	localparam logic [4:0] S_UPD     = 5'd8;
	localparam logic [4:0] S_SUM     = 5'd9;
	localparam logic [4:0] S_SL_MUL  = 5'd10;
	localparam logic [4:0] S_SL_SUB  = 5'd11;
	localparam logic [4:0] S_SL_GO   = 5'd12;
	localparam logic [4:0] S_SL_WAIT = 5'd13;
	localparam logic [4:0] S_MN_GO   = 5'd14;
	localparam logic [4:0] S_MN_WAIT = 5'd15;
	localparam logic [4:0] S_VAR     = 5'd16;
	localparam logic [4:0] S_VR_GO   = 5'd17;
	localparam logic [4:0] S_VR_WAIT = 5'd18;
	localparam logic [4:0] S_DONE    = 5'd19;

	logic [4:0] state_q;

	// filter state
	logic [LAT_W-1:0]  est_q;
	logic [ERR_W-1:0]  err_q;
	logic [AW-1:0]     head_q, start_q;
	logic [CW-1:0]     cnt_q;

	// per-word working registers
	logic [LAT_W-1:0]  x_q, d_q;
	logic              xge_q;
	logic [ERR_W-1:0]  pe_q, enew_q;
	logic [ERR_W:0]    den_q;
	logic [ERR_W+CFG_W-1:0] pmn_q;
	logic [GAIN_W-1:0] gain_q;
	logic [LAT_W+GAIN_W-1:0] mvp_q;
	logic [SYW-1:0]    sy_q;
	logic [SXYW-1:0]   sxy_q;
	logic [SXW-1:0]    sx_q;
	logic [SX2W-1:0]   sx2_q;
	logic [VSW-1:0]    vsum_q;
	logic [DIV_W-1:0]  a_q, b_q, nsx2_q, sxsq_q, mag_q, den2_q;
	logic              neg_q;
	logic [LAT_W-1:0]  mean_q;
	logic [SLOPE_W-1:0] slope_q;
	logic [VAR_W-1:0]  var_q;

	// sweep pipeline
	logic [LAT_W-1:0]  win_mem_q [WINDOW];
	logic [AW-1:0]     rd_addr_q;
	logic [CW-1:0]     iss_q;
	logic              issue;
	logic              v_s1, v_s2, v_s3;
	logic [LAT_W-1:0]  rdata_s1, y_s2, y_s3, dev_s2;
	logic [AW-1:0]     idx_s1, idx_s2, idx_s3;
	logic [LAT_W+AW-1:0] prod_s3;
	logic [2*AW-1:0]   isq_s3;
	logic [2*LAT_W-1:0] sq_s3;
	logic              sweep_done;

	// update-step combinational values
	logic [ERR_W:0]    pe_sum;
	logic [LAT_W+GAIN_W-1:0] mv_r;
	logic [LAT_W-1:0]  mv;
	logic [LAT_W-1:0]  est_nx;
	logic [AW-1:0]     head_nx;
	logic [CW-1:0]     cnt_nx;
	logic [LAT_W-1:0]  sl_sat;
	logic              out_free;

	assign pe_sum  = {1'b0, err_q} + (ERR_W + 1)'(cfg.process_noise);
	assign mv_r    = mvp_q + (LAT_W + GAIN_W)'(32768);
	assign mv      = mv_r[LAT_W+GAIN_W-1:16] > (LAT_W + GAIN_W - 16)'(LAT_MAX)
		? LAT_MAX : mv_r[16+LAT_W-1:16];
	assign est_nx  = xge_q ? est_q + mv : est_q - mv;
	assign head_nx = (head_q == AW'(WINDOW - 1)) ? '0 : head_q + 1'b1;
	assign cnt_nx  = (cnt_q == CW'(WINDOW)) ? cnt_q : cnt_q + 1'b1;
	assign sl_sat  = (div_rsp.quotient > DIV_W'(SLOPE_MAX))
		? SLOPE_MAX : div_rsp.quotient[LAT_W-1:0];

	assign issue      = ((state_q == S_SUM) || (state_q == S_VAR)) && (iss_q != cnt_q);
	assign sweep_done = (iss_q == cnt_q) && !v_s1 && !v_s2 && !v_s3;
	assign q_pop      = (state_q == S_IDLE) && q_head.valid;
	assign out_free   = !out_valid || !out_stall;

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = DIV_W'(den_q);
		unique case (state_q)
			S_G_GO: begin
				div_req.start    = (den_q != '0);
				div_req.dividend = DIV_W'({pe_q, 16'd0}) + DIV_W'(den_q >> 1);
			end
			S_E_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIV_W'(pmn_q) + DIV_W'(den_q >> 1);
			end
			S_SL_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = mag_q + (den2_q >> 1);
				div_req.divisor  = den2_q;
			end
			S_MN_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIV_W'(sy_q) + DIV_W'(cnt_q >> 1);
				div_req.divisor  = DIV_W'(cnt_q);
			end
			S_VR_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIV_W'(vsum_q) + DIV_W'(cnt_q >> 1);
				div_req.divisor  = DIV_W'(cnt_q);
			end
			default: begin
			end
		endcase
	end

	// control and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			est_q     <= '0;
			err_q     <= ERR_RESET;
			head_q    <= '0;
			cnt_q     <= '0;
			out_valid <= 1'b0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (state_q == S_DONE && out_free)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE:   if (q_head.valid) state_q <= S_PREP;
				S_PREP:   state_q <= S_DEN;
				S_DEN:    state_q <= S_G_GO;
				S_G_GO:   state_q <= (den_q == '0) ? S_MV : S_G_WAIT;
				S_G_WAIT: if (div_rsp.done) state_q <= S_E_GO;
				S_E_GO:   state_q <= S_E_WAIT;
				S_E_WAIT: if (div_rsp.done) state_q <= S_MV;
				S_MV:     state_q <= S_UPD;
				S_UPD: begin
					est_q   <= est_nx;
					err_q   <= enew_q;
					head_q  <= head_nx;
					cnt_q   <= cnt_nx;
					state_q <= S_SUM;
				end
				S_SUM: begin
					if (sweep_done) begin
						priority if (cnt_q >= CW'(MIN_SLOPE_N))
							state_q <= S_SL_MUL;
						else if (cnt_q >= CW'(MIN_VAR_N))
							state_q <= S_MN_GO;
						else
							state_q <= S_DONE;
					end
				end
				S_SL_MUL:  state_q <= S_SL_SUB;
				S_SL_SUB:  state_q <= S_SL_GO;
				S_SL_GO:   state_q <= S_SL_WAIT;
				S_SL_WAIT: if (div_rsp.done) state_q <= S_MN_GO;
				S_MN_GO:   state_q <= S_MN_WAIT;
				S_MN_WAIT: if (div_rsp.done) state_q <= S_VAR;
				S_VAR:     if (sweep_done) state_q <= S_VR_GO;
				S_VR_GO:   state_q <= S_VR_WAIT;
				S_VR_WAIT: if (div_rsp.done) state_q <= S_DONE;
				S_DONE:    if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				x_q <= q_head.sample;
			end
			S_PREP: begin
				pe_q  <= pe_sum[ERR_W] ? '1 : pe_sum[ERR_W-1:0];
				xge_q <= (x_q >= est_q);
				d_q   <= (x_q >= est_q) ? x_q - est_q : est_q - x_q;
			end
			S_DEN: begin
				den_q <= {1'b0, pe_q} + (ERR_W + 1)'(cfg.measurement_noise);
				pmn_q <= pe_q * cfg.measurement_noise;
			end
			S_G_GO: begin
				gain_q <= '0;
				enew_q <= '0;
			end
			S_G_WAIT: if (div_rsp.done) gain_q <= div_rsp.quotient[GAIN_W-1:0];
			S_E_WAIT: if (div_rsp.done) enew_q <= div_rsp.quotient[ERR_W-1:0];
			S_MV: begin
				mvp_q <= d_q * gain_q;
			end
			S_UPD: begin
				// oldest entry sits at the head once the window is full
				start_q   <= (cnt_nx == CW'(WINDOW)) ? head_nx : '0;
				rd_addr_q <= (cnt_nx == CW'(WINDOW)) ? head_nx : '0;
				iss_q     <= '0;
				sy_q      <= '0;
				sxy_q     <= '0;
				sx_q      <= '0;
				sx2_q     <= '0;
				slope_q   <= '0;
				var_q     <= '0;
			end
			S_SL_MUL: begin
				a_q    <= DIV_W'(cnt_q) * DIV_W'(sxy_q);
				b_q    <= DIV_W'(sx_q) * DIV_W'(sy_q);
				nsx2_q <= DIV_W'(cnt_q) * DIV_W'(sx2_q);
				sxsq_q <= DIV_W'(sx_q) * DIV_W'(sx_q);
			end
			S_SL_SUB: begin
				neg_q  <= (a_q < b_q);
				mag_q  <= (a_q < b_q) ? b_q - a_q : a_q - b_q;
				den2_q <= nsx2_q - sxsq_q;
			end
			S_SL_WAIT: begin
				if (div_rsp.done)
					slope_q <= neg_q ? SLOPE_W'(-{1'b0, sl_sat}) : SLOPE_W'(sl_sat);
			end
			S_MN_WAIT: begin
				if (div_rsp.done) begin
					mean_q    <= div_rsp.quotient[LAT_W-1:0];
					iss_q     <= '0;
					rd_addr_q <= start_q;
					vsum_q    <= '0;
				end
			end
			S_VR_WAIT: if (div_rsp.done) var_q <= div_rsp.quotient[VAR_W-1:0];
			default: begin
			end
		endcase

		if (issue) begin
			iss_q     <= iss_q + 1'b1;
			rd_addr_q <= (rd_addr_q == AW'(WINDOW - 1)) ? '0 : rd_addr_q + 1'b1;
		end
		idx_s1  <= iss_q[AW-1:0];
		y_s2    <= rdata_s1;
		idx_s2  <= idx_s1;
		dev_s2  <= (rdata_s1 >= mean_q) ? rdata_s1 - mean_q : mean_q - rdata_s1;
		y_s3    <= y_s2;
		idx_s3  <= idx_s2;
		prod_s3 <= idx_s2 * y_s2;
		isq_s3  <= idx_s2 * idx_s2;
		sq_s3   <= dev_s2 * dev_s2;
		if (v_s3 && state_q == S_SUM) begin
			sy_q  <= sy_q + SYW'(y_s3);
			sxy_q <= sxy_q + SXYW'(prod_s3);
			sx_q  <= sx_q + SXW'(idx_s3);
			sx2_q <= sx2_q + SX2W'(isq_s3);
		end
		if (v_s3 && state_q == S_VAR)
			vsum_q <= vsum_q + VSW'((sq_s3 + (2 * LAT_W)'(32768)) >> 16);

		if (state_q == S_DONE && out_free) begin
			filtered_latency <= est_q;
			trend_slope      <= slope_q;
			latency_variance <= var_q;
			window_fill      <= FILL_W'(cnt_q);
		end
	end

	// window store
	always_ff @(posedge clk) begin
		if (state_q == S_UPD)
			win_mem_q[head_q] <= est_nx;
		rdata_s1 <= win_mem_q[rd_addr_q];
	end

endmodule
